/* rtl/dte_pkg.sv */
// Shared types and constants of the directory entry table.
// No dependencies; every other file of the block but dte_ram imports this package.
package dte_pkg;

  localparam int SLOTS      = 32;
  localparam int INODE_BITS = 16;

  localparam int NAME_W     = 32;
  localparam int INODE_IO_W = 16;
  localparam int SLOT_IO_W  = 5;
  localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CUR_W      = $clog2(SLOTS + 1);
  localparam int INO_W      = (INODE_BITS < INODE_IO_W) ? INODE_BITS : INODE_IO_W;
  localparam int ENTRY_W    = NAME_W + INO_W;

  typedef enum logic [2:0] {
    OP_OPEN   = 3'd0,
    OP_CLOSE  = 3'd1,
    OP_CREATE = 3'd2,
    OP_DELETE = 3'd3,
    OP_READ   = 3'd4,
    OP_REWIND = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_OPEN  = 3'd1,
    ST_BAD_NAME  = 3'd2,
    ST_EXISTS    = 3'd3,
    ST_NO_SPACE  = 3'd4,
    ST_NOT_FOUND = 3'd5,
    ST_END       = 3'd6
  } status_t;

  // request to the slot compare unit
  typedef struct packed {
    logic vld;      // a slot's data is on the memory read port
    logic used;     // that slot holds an entry
    logic by_name;  // hit needs name equality, else any used slot hits
  } match_req_t;

  // clear every byte after the first zero byte
  function automatic logic [NAME_W-1:0] normalize(input logic [NAME_W-1:0] n);
    logic [NAME_W-1:0] res;
    logic              live;
    res  = '0;
    live = 1'b1;
    for (int b = 0; b < NAME_W / 8; b++) begin
      if (n[b*8 +: 8] == 8'd0) live = 1'b0;
      if (live) res[b*8 +: 8] = n[b*8 +: 8];
    end
    return res;
  endfunction

endpackage

/* rtl/dte_in_if.sv */
// Command channel of the directory entry table: valid/ready plus payload.
// Depends on dte_pkg for field widths.
interface dte_in_if
  import dte_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [2:0]            op;
  logic [NAME_W-1:0]     entry_name;
  logic [INODE_IO_W-1:0] inode_number;

  modport source (output valid, output op, output entry_name, output inode_number,
                  input ready);
  modport sink   (input valid, input op, input entry_name, input inode_number,
                  output ready);
endinterface

/* rtl/dte_out_if.sv */
// Result channel of the directory entry table: valid/ready plus payload.
// Depends on dte_pkg for field widths.
interface dte_out_if
  import dte_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [2:0]            status;
  logic [SLOT_IO_W-1:0]  slot_index;
  logic [NAME_W-1:0]     found_name;
  logic [INODE_IO_W-1:0] found_inode;

  modport source (output valid, output status, output slot_index, output found_name,
                  output found_inode, input ready);
  modport sink   (input valid, input status, input slot_index, input found_name,
                  input found_inode, output ready);
endinterface

/* rtl/directory_entry_table_unit.sv */
// Directory entry table: SLOTS slots of {4-byte name, inode}, one command in, one result out.
// Open, close, rewind, undefined ops, reads with the cursor at the end and commands rejected by
// the open/name checks answer straight from idle. Create, delete and read-next walk the slot
// memory one slot per cycle through its single registered read port: create always walks all
// slots unless the name already exists, delete stops at the match, read-next stops at the next
// used slot at or after the cursor.
// Slot occupancy lives in flip-flops cleared at reset, so no clearing pass is needed.
// A new command is taken while the previous result is being transferred out.
// Depends on dte_pkg, dte_in_if, dte_out_if, dte_ram and dte_match.
module directory_entry_table_unit
  import dte_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  dte_in_if.sink    in_ch,
  dte_out_if.source out_ch
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t                state_r, state_nxt;
  logic                  is_open_r, is_open_nxt;
  logic [CUR_W-1:0]      cursor_r, cursor_nxt;
  logic [CUR_W-1:0]      idx_r, idx_nxt;
  logic                  cmp_vld_r, cmp_vld_nxt;
  logic [SLOT_W-1:0]     cmp_idx_r, cmp_idx_nxt;
  logic                  free_vld_r, free_vld_nxt;
  logic [SLOT_W-1:0]     free_idx_r, free_idx_nxt;
  op_t                   op_r, op_nxt;
  logic [NAME_W-1:0]     key_r, key_nxt;
  logic [INO_W-1:0]      ino_r, ino_nxt;
  logic [SLOTS-1:0]      used_r, used_nxt;

  logic                  out_valid_r, out_valid_nxt;
  status_t               status_r, status_nxt;
  logic [SLOT_IO_W-1:0]  slot_r, slot_nxt;
  logic [NAME_W-1:0]     fname_r, fname_nxt;
  logic [INODE_IO_W-1:0] finode_r, finode_nxt;

  logic                  in_fire;
  op_t                   op_in;
  logic [NAME_W-1:0]     nm_in;
  logic                  name_ok;
  logic                  ram_we;
  logic [SLOT_W-1:0]     ram_waddr;
  logic [ENTRY_W-1:0]    ram_rdata;
  match_req_t            mreq;
  logic                  hit, free;
  logic                  last_cmp;
  logic                  have_free;
  logic [SLOT_W-1:0]     free_slot;

  assign in_ch.ready = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign op_in       = op_t'(in_ch.op);
  assign nm_in       = normalize(in_ch.entry_name);
  assign name_ok     = nm_in[7:0] != 8'd0;

  dte_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata({key_r, ino_r}),
    .raddr(idx_r[SLOT_W-1:0]),
    .rdata(ram_rdata)
  );

  assign mreq.vld     = cmp_vld_r;
  assign mreq.used    = used_r[cmp_idx_r];
  assign mreq.by_name = (op_r != OP_READ);

  dte_match u_match (
    .req        (mreq),
    .stored_name(ram_rdata[ENTRY_W-1 -: NAME_W]),
    .key        (key_r),
    .hit        (hit),
    .free       (free)
  );

  assign last_cmp  = cmp_idx_r == SLOT_W'(SLOTS - 1);
  assign have_free = free_vld_r || free;
  assign free_slot = free_vld_r ? free_idx_r : cmp_idx_r;
  assign ram_waddr = free_slot;

  always_comb begin
    state_nxt     = state_r;
    is_open_nxt   = is_open_r;
    cursor_nxt    = cursor_r;
    idx_nxt       = idx_r;
    cmp_vld_nxt   = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    free_vld_nxt  = free_vld_r;
    free_idx_nxt  = free_idx_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    ino_nxt       = ino_r;
    used_nxt      = used_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    status_nxt    = status_r;
    slot_nxt      = slot_r;
    fname_nxt     = fname_r;
    finode_nxt    = finode_r;
    ram_we        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt        = op_in;
          key_nxt       = nm_in;
          ino_nxt       = in_ch.inode_number[INO_W-1:0];
          idx_nxt       = '0;
          free_vld_nxt  = 1'b0;
          out_valid_nxt = 1'b1;
          status_nxt    = ST_OK;
          slot_nxt      = '0;
          fname_nxt     = '0;
          finode_nxt    = '0;
          unique case (op_in)
            OP_OPEN: begin
              if (!name_ok) begin
                status_nxt = ST_BAD_NAME;
              end else begin
                is_open_nxt = 1'b1;
                cursor_nxt  = '0;
              end
            end
            OP_CLOSE: begin
              if (!name_ok) begin
                status_nxt = ST_BAD_NAME;
              end else if (!is_open_r) begin
                status_nxt = ST_NOT_OPEN;
              end else begin
                is_open_nxt = 1'b0;
                cursor_nxt  = '0;
              end
            end
            OP_CREATE, OP_DELETE: begin
              if (!is_open_r) begin
                status_nxt = ST_NOT_OPEN;
              end else if (!name_ok) begin
                status_nxt = ST_BAD_NAME;
              end else begin
                out_valid_nxt = 1'b0;
                state_nxt     = S_SCAN;
              end
            end
            OP_READ: begin
              if (!is_open_r) begin
                status_nxt = ST_NOT_OPEN;
              end else if (cursor_r == CUR_W'(SLOTS)) begin
                status_nxt = ST_END;
              end else begin
                idx_nxt       = cursor_r;
                out_valid_nxt = 1'b0;
                state_nxt     = S_SCAN;
              end
            end
            OP_REWIND: begin
              if (!is_open_r) status_nxt = ST_NOT_OPEN;
              else cursor_nxt = '0;
            end
            default: ;
          endcase
        end
      end

      S_SCAN: begin
        // read issue runs one slot ahead of the compare
        if (idx_r < CUR_W'(SLOTS)) begin
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = idx_r[SLOT_W-1:0];
          idx_nxt     = idx_r + CUR_W'(1);
        end
        if (free && !free_vld_r) begin
          free_vld_nxt = 1'b1;
          free_idx_nxt = cmp_idx_r;
        end
        if (hit || (cmp_vld_r && last_cmp)) begin
          state_nxt     = S_IDLE;
          cmp_vld_nxt   = 1'b0;
          out_valid_nxt = 1'b1;
          if (hit) begin
            priority case (op_r)
              OP_CREATE: status_nxt = ST_EXISTS;
              OP_DELETE: begin
                slot_nxt             = SLOT_IO_W'(cmp_idx_r);
                finode_nxt           = INODE_IO_W'(ram_rdata[INO_W-1:0]);
                used_nxt[cmp_idx_r]  = 1'b0;
              end
              default: begin
                slot_nxt   = SLOT_IO_W'(cmp_idx_r);
                fname_nxt  = ram_rdata[ENTRY_W-1 -: NAME_W];
                finode_nxt = INODE_IO_W'(ram_rdata[INO_W-1:0]);
                cursor_nxt = CUR_W'(cmp_idx_r) + CUR_W'(1);
              end
            endcase
          end else begin
            priority case (op_r)
              OP_CREATE: begin
                if (have_free) begin
                  ram_we              = 1'b1;
                  used_nxt[free_slot] = 1'b1;
                  slot_nxt            = SLOT_IO_W'(free_slot);
                end else begin
                  status_nxt = ST_NO_SPACE;
                end
              end
              OP_DELETE: status_nxt = ST_NOT_FOUND;
              default: begin
                status_nxt = ST_END;
                cursor_nxt = CUR_W'(SLOTS);
              end
            endcase
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      is_open_r   <= 1'b0;
      cursor_r    <= '0;
      idx_r       <= '0;
      cmp_vld_r   <= 1'b0;
      free_vld_r  <= 1'b0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      is_open_r   <= is_open_nxt;
      cursor_r    <= cursor_nxt;
      idx_r       <= idx_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      free_vld_r  <= free_vld_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r  <= cmp_idx_nxt;
    free_idx_r <= free_idx_nxt;
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    ino_r      <= ino_nxt;
    status_r   <= status_nxt;
    slot_r     <= slot_nxt;
    fname_r    <= fname_nxt;
    finode_r   <= finode_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.slot_index  = slot_r;
  assign out_ch.found_name  = fname_r;
  assign out_ch.found_inode = finode_r;

  // result register is always empty while a scan is running
  a_scan_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> !out_valid_r)
    else $error("result pending during slot scan");

  // scans only run against an open table
  a_scan_open: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> is_open_r)
    else $error("slot scan while table closed");

  // create only fills a free slot
  a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (!used_r[ram_waddr] && op_r == OP_CREATE))
    else $error("create overwrote a used slot");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= CUR_W'(SLOTS))
    else $error("read cursor beyond table");

  // a slot write sets its occupancy bit on the next edge
  a_write_marks: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> used_r[$past(ram_waddr)])
    else $error("filled slot not marked used");

endmodule

/* rtl/dte_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* rtl/dte_match.sv */
// Slot compare unit, shared by create, delete and read-next scans.
// Depends on dte_pkg.
module dte_match
  import dte_pkg::*;
(
  input  match_req_t        req,
  input  logic [NAME_W-1:0] stored_name,
  input  logic [NAME_W-1:0] key,
  output logic              hit,
  output logic              free
);
  assign hit  = req.vld && req.used && (!req.by_name || stored_name == key);
  assign free = req.vld && !req.used;
endmodule

/* sim/directory_entry_table_unit_tb.sv */
// Self-checking testbench for directory_entry_table_unit: directed and random command
// streams with a predictor of the slot table, open flag and read cursor.
// Depends on rtl/dte_pkg.sv, rtl/dte_in_if.sv, rtl/dte_out_if.sv and the block's RTL.
`timescale 1ns / 100ps

module directory_entry_table_unit_tb;
  import dte_pkg::*;

  localparam logic [2:0] OP_UNDEF_LO = 3'd6;
  localparam logic [2:0] OP_UNDEF_HI = 3'd7;
  localparam int NAME_POOL = 40;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    status_t               status;
    logic [SLOT_IO_W-1:0]  slot;
    logic [NAME_W-1:0]     name;
    logic [INODE_IO_W-1:0] inode;
  } dir_result_t;

  logic clk = 1'b0;
  logic rst_n;

  dte_in_if  in_ch ();
  dte_out_if out_ch ();

  directory_entry_table_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predicted directory state
  logic [NAME_W-1:0]     dir_names  [SLOTS];
  logic [INODE_IO_W-1:0] dir_inodes [SLOTS];
  bit                    tbl_is_open;
  int                    dir_cursor;

  dir_result_t dir_results_due [$];
  logic [NAME_W-1:0] name_pool [NAME_POOL];

  int send_idle_pct;
  int recv_idle_pct;
  int hold_left;
  int cmds_sent;
  int results_checked;
  int fail_count;
  int status_seen [8];

  // bytes up to, not including, the first zero byte
  function automatic logic [NAME_W-1:0] name_keep_mask(input logic [NAME_W-1:0] n);
    logic [NAME_W-1:0] m;
    m = '0;
    for (int b = 0; b < NAME_W / 8; b++) begin
      if (n[8*b +: 8] == 8'h00) break;
      m[8*b +: 8] = 8'hFF;
    end
    return m;
  endfunction

  function automatic int dir_find(input logic [NAME_W-1:0] nm);
    for (int i = 0; i < SLOTS; i++)
      if (dir_names[i][7:0] != 8'h00 && dir_names[i] == nm) return i;
    return -1;
  endfunction

  task automatic predict_dir_result(input logic [2:0] op, input logic [NAME_W-1:0] raw_name,
                                    input logic [INODE_IO_W-1:0] ino);
    dir_result_t       r;
    logic [NAME_W-1:0] nm;
    logic [INODE_IO_W-1:0] ino_m;
    bit                name_ok;
    int                pos;
    r       = '0;
    r.status = ST_OK;
    nm      = raw_name & name_keep_mask(raw_name);
    ino_m   = ino & INODE_IO_W'((64'd1 << INO_W) - 1);
    name_ok = (nm[7:0] != 8'h00);
    pos     = -1;
    case (op)
      OP_OPEN: begin
        if (!name_ok) r.status = ST_BAD_NAME;
        else begin
          tbl_is_open = 1'b1;
          dir_cursor  = 0;
        end
      end
      OP_CLOSE: begin
        if (!name_ok) r.status = ST_BAD_NAME;
        else if (!tbl_is_open) r.status = ST_NOT_OPEN;
        else begin
          tbl_is_open = 1'b0;
          dir_cursor  = 0;
        end
      end
      OP_CREATE: begin
        if (!tbl_is_open) r.status = ST_NOT_OPEN;
        else if (!name_ok) r.status = ST_BAD_NAME;
        else if (dir_find(nm) >= 0) r.status = ST_EXISTS;
        else begin
          for (int i = 0; i < SLOTS; i++)
            if (pos < 0 && dir_names[i][7:0] == 8'h00) pos = i;
          if (pos < 0) r.status = ST_NO_SPACE;
          else begin
            dir_names[pos]  = nm;
            dir_inodes[pos] = ino_m;
            r.slot = SLOT_IO_W'(pos);
          end
        end
      end
      OP_DELETE: begin
        if (!tbl_is_open) r.status = ST_NOT_OPEN;
        else if (!name_ok) r.status = ST_BAD_NAME;
        else begin
          pos = dir_find(nm);
          if (pos < 0) r.status = ST_NOT_FOUND;
          else begin
            r.inode = dir_inodes[pos];
            r.slot  = SLOT_IO_W'(pos);
            dir_names[pos]  = '0;
            dir_inodes[pos] = '0;
          end
        end
      end
      OP_READ: begin
        if (!tbl_is_open) r.status = ST_NOT_OPEN;
        else begin
          for (int i = dir_cursor; i < SLOTS; i++)
            if (pos < 0 && dir_names[i][7:0] != 8'h00) pos = i;
          if (pos < 0) begin
            r.status   = ST_END;
            dir_cursor = SLOTS;
          end else begin
            r.slot     = SLOT_IO_W'(pos);
            r.name     = dir_names[pos];
            r.inode    = dir_inodes[pos];
            dir_cursor = pos + 1;
          end
        end
      end
      OP_REWIND: begin
        if (!tbl_is_open) r.status = ST_NOT_OPEN;
        else dir_cursor = 0;
      end
      default: ;
    endcase
    dir_results_due.push_back(r);
  endtask

  // present one command, hold it until the transfer, then predict its result
  task automatic send_cmd(input logic [2:0] op, input logic [NAME_W-1:0] nm,
                          input logic [INODE_IO_W-1:0] ino);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.op           <= op;
    in_ch.entry_name   <= nm;
    in_ch.inode_number <= ino;
    do @(posedge clk); while (!in_ch.ready);
    predict_dir_result(op, nm, ino);
    cmds_sent++;
  endtask

  task automatic report_failure(input string what, input dir_result_t want,
                                input dir_result_t got);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("%0t: %s: want st=%0d slot=%0d name=%h ino=%h, got st=%0d slot=%0d name=%h ino=%h",
               $realtime, what, want.status, want.slot, want.name, want.inode,
               got.status, got.slot, got.name, got.inode);
  endtask

  // long receiver hold-off, counted down here
  always @(posedge clk)
    if (hold_left > 0) hold_left <= hold_left - 1;

  // result side: check every transfer, then pick next cycle's ready
  always @(posedge clk) begin
    dir_result_t got;
    dir_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.status, out_ch.slot_index, out_ch.found_name, out_ch.found_inode};
        results_checked++;
        status_seen[out_ch.status]++;
        if (dir_results_due.size() == 0) begin
          report_failure("unexpected result", '0, got);
        end else begin
          want = dir_results_due.pop_front();
          if (got !== want) report_failure("result mismatch", want, got);
        end
      end
      out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic test_directed_cases();
    send_idle_pct = 31;
    recv_idle_pct = 64;
    // everything but open refused while closed
    send_cmd(OP_READ,   32'h0000_0041, 16'h0000);
    send_cmd(OP_REWIND, 32'h0000_0041, 16'h0000);
    send_cmd(OP_CREATE, 32'hFFFF_FFFF, 16'hFFFF);
    send_cmd(OP_DELETE, 32'hFFFF_FFFF, 16'h0000);
    send_cmd(OP_CLOSE,  32'h0000_0041, 16'h0000);
    // name is checked before the open flag on close
    send_cmd(OP_CLOSE,  32'hFFFF_FF00, 16'h0000);
    send_cmd(OP_OPEN,   32'h0000_0000, 16'h0000);
    send_cmd(OP_OPEN,   32'hFFFF_FFFF, 16'h0000);
    send_cmd(OP_CREATE, 32'hFFFF_FFFF, 16'hFFFF);
    send_cmd(OP_CREATE, 32'hFFFF_FFFF, 16'h0000);
    send_cmd(OP_CREATE, 32'h8000_0000, 16'h1234);
    // garbage past the first zero byte is dropped, so these two collide
    send_cmd(OP_CREATE, 32'hA5B6_0041, 16'h8001);
    send_cmd(OP_CREATE, 32'h0000_0041, 16'h7FFE);
    send_cmd(OP_READ,   32'h0000_0000, 16'h0000);
    send_cmd(OP_READ,   32'h0000_0000, 16'h0000);
    send_cmd(OP_READ,   32'h0000_0000, 16'h0000);
    send_cmd(OP_REWIND, 32'h0000_0000, 16'h0000);
    send_cmd(OP_READ,   32'h0000_0000, 16'h0000);
    send_cmd(OP_DELETE, 32'h7F00_0041, 16'hFFFF);
    send_cmd(OP_DELETE, 32'h0000_0041, 16'h0000);
    send_cmd(OP_DELETE, 32'h0000_0100, 16'h0000);
    send_cmd(OP_UNDEF_LO, 32'hFFFF_FFFF, 16'hFFFF);
    send_cmd(OP_UNDEF_HI, 32'h0000_0000, 16'h0000);
    send_cmd(OP_OPEN,   32'h0000_0001, 16'h0000);
    send_cmd(OP_CLOSE,  32'h0000_0080, 16'h0000);
    send_cmd(OP_READ,   32'h0000_0000, 16'h0000);
  endtask

  // fill every slot, overflow, scan the whole table, then punch holes and refill
  task automatic test_fill_and_scan();
    logic [NAME_W-1:0] nm;
    send_cmd(OP_OPEN, 32'h0000_002F, 16'h0000);
    for (int i = 0; i < SLOTS + 2; i++) begin
      nm = {8'(i * 7), 8'h66, 8'h2E, 8'(8'h30 + i)};
      send_cmd(OP_CREATE, nm, 16'($urandom));
    end
    send_cmd(OP_REWIND, 32'h0000_0000, 16'h0000);
    repeat (SLOTS + 2) send_cmd(OP_READ, 32'h0000_0000, 16'h0000);
    for (int i = 0; i < SLOTS + 2; i += 3) begin
      nm = {8'(i * 7), 8'h66, 8'h2E, 8'(8'h30 + i)};
      send_cmd(OP_DELETE, nm, 16'h0000);
    end
    for (int i = 0; i < 6; i++)
      send_cmd(OP_CREATE, {8'h00, 8'h21, 8'(8'h41 + i), 8'h7A}, 16'($urandom));
    send_cmd(OP_CLOSE, 32'h0000_002F, 16'h0000);
  endtask

  // mostly pool names so creates collide, deletes hit and the table fills
  task automatic run_random_traffic(input int n_cmds, input int tx_idle, input int rx_idle);
    logic [2:0]        op;
    logic [NAME_W-1:0] nm;
    logic [NAME_W-1:0] keep;
    int                pick;
    send_idle_pct = tx_idle;
    recv_idle_pct = rx_idle;
    repeat (n_cmds) begin
      pick = $urandom_range(99);
      if (!tbl_is_open && $urandom_range(9) < 7) op = OP_OPEN;
      else if (pick < 38) op = OP_CREATE;
      else if (pick < 62) op = OP_DELETE;
      else if (pick < 80) op = OP_READ;
      else if (pick < 86) op = OP_REWIND;
      else if (pick < 91) op = OP_OPEN;
      else if (pick < 96) op = OP_CLOSE;
      else op = ($urandom_range(1) != 0) ? OP_UNDEF_HI : OP_UNDEF_LO;
      pick = $urandom_range(99);
      if (pick < 75) begin
        nm   = name_pool[$urandom_range(NAME_POOL - 1)];
        keep = name_keep_mask(nm);
        if ($urandom_range(1) != 0) nm = nm | ($urandom & ~((keep << 8) | 32'hFF));
      end else if (pick < 90) begin
        nm = $urandom;
      end else begin
        nm = $urandom & 32'hFFFF_FF00;
      end
      send_cmd(op, nm, 16'($urandom));
    end
  endtask

  // receiver stalls for a long stretch while commands keep coming
  task automatic test_output_backpressure();
    hold_left = 400;
    run_random_traffic(80, 64, 31);
  endtask

  initial begin
    logic [NAME_W-1:0] nm;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.op           = OP_OPEN;
    in_ch.entry_name   = '0;
    in_ch.inode_number = '0;
    hold_left          = 0;
    send_idle_pct      = 0;
    recv_idle_pct      = 0;
    tbl_is_open        = 1'b0;
    dir_cursor         = 0;
    for (int i = 0; i < SLOTS; i++) begin
      dir_names[i]  = '0;
      dir_inodes[i] = '0;
    end
    for (int i = 0; i < NAME_POOL; i++) begin
      nm      = $urandom;
      nm[7:0] = 8'($urandom_range(255, 1));
      for (int b = 1; b < NAME_W / 8; b++)
        if ($urandom_range(3) == 0) nm[8*b +: 8] = 8'h00;
      name_pool[i] = nm & name_keep_mask(nm);
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_fill_and_scan();
    run_random_traffic(390, 31, 64);
    test_output_backpressure();
    run_random_traffic(390, 64, 31);
    run_random_traffic(390, 0, 0);
    in_ch.valid <= 1'b0;

    while (dir_results_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("%0d commands, %0d results checked; ok %0d, not-open %0d, bad-name %0d",
             cmds_sent, results_checked, status_seen[ST_OK], status_seen[ST_NOT_OPEN],
             status_seen[ST_BAD_NAME]);
    $display("exists %0d, no-space %0d, not-found %0d, end-of-scan %0d, failures %0d",
             status_seen[ST_EXISTS], status_seen[ST_NO_SPACE], status_seen[ST_NOT_FOUND],
             status_seen[ST_END], fail_count);
    if (fail_count == 0 && dir_results_due.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", dir_results_due.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* files.f */
rtl/dte_pkg.sv
rtl/dte_in_if.sv
rtl/dte_out_if.sv
rtl/dte_ram.sv
rtl/dte_match.sv
rtl/directory_entry_table_unit.sv
sim/directory_entry_table_unit_tb.sv
